>>> rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the matrix vector multiply unit.
// ----------------------------------------------------------------------------
package mvm_pkg;

   localparam int MAX_ORDER_DEFAULT = 16;
   localparam int VALUE_W           = 32;
   localparam int FIELD_IDX_W       = 4;
   localparam int SIZE_W            = 5;
   localparam int FRAC_BITS         = 16;
   localparam int PROD_W            = 2 * VALUE_W;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

   typedef enum logic [1:0] {
      KIND_MATRIX  = 2'd0,
      KIND_VECTOR  = 2'd1,
      KIND_COMPUTE = 2'd2
   } kind_type;

   // load write broadcast to every cell of the chain
   typedef struct packed {
      logic                   mat_we;
      logic                   vec_we;
      logic [FIELD_IDX_W-1:0] row;
      logic [FIELD_IDX_W-1:0] col;
      logic [VALUE_W-1:0]     value;
   } wr_type;

endpackage

>>> rtl/mvm_cell.sv
// ----------------------------------------------------------------------------
// mvm_cell
// One column of the chain: holds x[j] and column j of the matrix, adds
// A[row][j]*x[j] to the partial sum passing through it.
// ----------------------------------------------------------------------------
module mvm_cell #(
   parameter int MAX_ORDER  = mvm_pkg::MAX_ORDER_DEFAULT,
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 4,
   parameter int ACC_W      = 69
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                active,
   input  mvm_pkg::wr_type     wr,
   input  logic                in_valid,
   input  logic                in_last,
   input  logic [IDX_W-1:0]    in_row,
   input  logic [ACC_W-1:0]    in_sum,
   output logic                out_valid,
   output logic                out_last,
   output logic [IDX_W-1:0]    out_row,
   output logic [ACC_W-1:0]    out_sum
);

   logic [mvm_pkg::VALUE_W-1:0] col_mem [MAX_ORDER];
   logic [mvm_pkg::VALUE_W-1:0] x_ff;
   logic [mvm_pkg::VALUE_W-1:0] a_rd_ff;
   logic [mvm_pkg::PROD_W-1:0]  prod_ff;
   logic [mvm_pkg::PROD_W-1:0]  prod_in;

   logic                        v1_ff, v2_ff, v3_ff;
   logic                        l1_ff, l2_ff, l3_ff;
   logic [IDX_W-1:0]            r1_ff, r2_ff, r3_ff;
   logic [ACC_W-1:0]            s1_ff, s2_ff, s3_ff;
   logic                        col_hit;
   logic                        row_ok;

   assign col_hit = (int'(wr.col) == CELL_INDEX);
   assign row_ok  = (int'(wr.row) < MAX_ORDER);

   // column store and vector entry
   always_ff @(posedge clock) begin
      if (wr.mat_we && col_hit && row_ok) begin
         col_mem[IDX_W'(wr.row)] <= wr.value;
      end
      if (wr.vec_we && col_hit) begin
         x_ff <= wr.value;
      end
      if (en) begin
         a_rd_ff <= col_mem[in_row];
      end
   end

   // columns beyond the order in use add nothing
   assign prod_in = active ? mvm_pkg::PROD_W'($signed(a_rd_ff) * $signed(x_ff))
                           : '0;

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff   <= in_row;
         s1_ff   <= in_sum;
         l1_ff   <= in_last;
         prod_ff <= prod_in;
         r2_ff   <= r1_ff;
         s2_ff   <= s1_ff;
         l2_ff   <= l1_ff;
         r3_ff   <= r2_ff;
         s3_ff   <= s2_ff + {{(ACC_W-mvm_pkg::PROD_W){prod_ff[mvm_pkg::PROD_W-1]}},
                             prod_ff};
         l3_ff   <= l2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_last  = l3_ff;
   assign out_row   = r3_ff;
   assign out_sum   = s3_ff;

endmodule

>>> rtl/matrix_vector_multiply_unit.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_unit
// Square matrix times vector in signed Q16.16, one cell per matrix column.
// ----------------------------------------------------------------------------
// req channel: tuser carries the kind. Kind 0 writes A[row][col], kind 1
// writes x[col]; neither gives a result. Kind 2 computes b = A*x over the
// order n set by csr (0 counts as 1, large values clip to MAX_ORDER) and
// returns n items on rsp, rows in order, tlast on the last.
// Each row's sum is floor-shifted by 16 bits and saturated; tuser flags it.
// Rows enter the cell chain one per cycle while rsp is not stalled; every
// cell adds its column's product through registered column read, multiply
// and add steps, and the results leave one per cycle, also barring a stall.
// req_tready stays low from a compute item until its last result sits in
// the output register; load items go one per cycle while it is high.
// A stall on rsp freezes the whole chain until the result is taken.
// Reset empties the chain and sets the order to 16; the stores keep their
// contents, which are undefined until written.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_unit #(
   parameter int MAX_ORDER = mvm_pkg::MAX_ORDER_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // row[3:0], col[7:4], value[39:8]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // row_index[3:0], product_value[35:4], zero
   output logic [0:0]  rsp_tuser,   // saturated[0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata    // size_in_use[4:0]
);

   localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int NW    = $clog2(MAX_ORDER + 1);
   localparam int CW    = (NW > mvm_pkg::SIZE_W) ? NW : mvm_pkg::SIZE_W;
   localparam int ACC_W = mvm_pkg::PROD_W + IDX_W + 1;
   localparam int TOP_W = ACC_W - (mvm_pkg::FRAC_BITS + mvm_pkg::VALUE_W - 1);

   logic [mvm_pkg::SIZE_W-1:0] size_ff;
   logic [NW-1:0]              n_ff;
   logic [NW-1:0]              n_in;
   logic [CW-1:0]              size_ext;
   logic                       busy_ff;
   logic                       issuing_ff;
   logic [IDX_W-1:0]           cnt_ff;
   logic                       issue_last;
   logic                       en;
   logic                       req_acc;
   mvm_pkg::kind_type          req_kind;
   mvm_pkg::wr_type            wr;

   logic                       ch_valid [MAX_ORDER+1];
   logic                       ch_last  [MAX_ORDER+1];
   logic [IDX_W-1:0]           ch_row   [MAX_ORDER+1];
   logic [ACC_W-1:0]           ch_sum   [MAX_ORDER+1];

   logic                       rsp_valid_ff;
   logic [3:0]                 rsp_row_ff;
   logic [31:0]                rsp_val_ff;
   logic                       rsp_sat_ff;
   logic                       rsp_last_ff;
   logic [TOP_W-1:0]           sum_top;
   logic                       fits;

   assign req_kind   = mvm_pkg::kind_type'(req_tuser);
   assign req_tready = !busy_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign en         = !rsp_valid_ff || rsp_tready;

   always_comb begin
      wr        = '0;
      wr.row    = req_tdata[3:0];
      wr.col    = req_tdata[7:4];
      wr.value  = req_tdata[39:8];
      unique case (req_kind)
         mvm_pkg::KIND_MATRIX: wr.mat_we = req_acc;
         mvm_pkg::KIND_VECTOR: wr.vec_we = req_acc;
         default:              wr.mat_we = 1'b0;
      endcase
   end

   // order in use, clipped to 1..MAX_ORDER
   assign size_ext = CW'(size_ff);
   always_comb begin
      if (size_ext == '0) begin
         n_in = NW'(1);
      end else if (size_ext > CW'(MAX_ORDER)) begin
         n_in = NW'(MAX_ORDER);
      end else begin
         n_in = NW'(size_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mvm_pkg::SIZE_RESET;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   assign issue_last = ((NW'(cnt_ff) + NW'(1)) == n_ff);

   // row sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         issuing_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         if (req_acc && req_kind == mvm_pkg::KIND_COMPUTE) begin
            busy_ff    <= 1'b1;
            issuing_ff <= 1'b1;
            cnt_ff     <= '0;
         end else begin
            if (en && issuing_ff) begin
               cnt_ff <= cnt_ff + IDX_W'(1);
               if (issue_last) begin
                  issuing_ff <= 1'b0;
               end
            end
            if (en && ch_valid[MAX_ORDER] && ch_last[MAX_ORDER]) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_kind == mvm_pkg::KIND_COMPUTE) begin
         n_ff <= n_in;
      end
   end

   assign ch_valid[0] = issuing_ff;
   assign ch_last[0]  = issue_last;
   assign ch_row[0]   = cnt_ff;
   assign ch_sum[0]   = '0;

   for (genvar j = 0; j < MAX_ORDER; j++) begin : g_cell
      logic active;
      assign active = (NW'(j) < n_ff);
      mvm_cell #(
         .MAX_ORDER  (MAX_ORDER),
         .CELL_INDEX (j),
         .IDX_W      (IDX_W),
         .ACC_W      (ACC_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .active    (active),
         .wr        (wr),
         .in_valid  (ch_valid[j]),
         .in_last   (ch_last[j]),
         .in_row    (ch_row[j]),
         .in_sum    (ch_sum[j]),
         .out_valid (ch_valid[j+1]),
         .out_last  (ch_last[j+1]),
         .out_row   (ch_row[j+1]),
         .out_sum   (ch_sum[j+1])
      );
   end

   // shifted sum fits 32 bits when its top bits are all sign copies
   assign sum_top = ch_sum[MAX_ORDER][ACC_W-1:ACC_W-TOP_W];
   assign fits    = (sum_top == '0) || (sum_top == '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ch_valid[MAX_ORDER];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_row_ff  <= 4'(ch_row[MAX_ORDER]);
         rsp_last_ff <= ch_last[MAX_ORDER];
         rsp_sat_ff  <= !fits;
         if (fits) begin
            rsp_val_ff <= ch_sum[MAX_ORDER][mvm_pkg::FRAC_BITS +: 32];
         end else if (ch_sum[MAX_ORDER][ACC_W-1]) begin
            rsp_val_ff <= 32'h8000_0000;
         end else begin
            rsp_val_ff <= 32'h7FFF_FFFF;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_val_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
